>>> rtl/bdq_pkg.sv
package bdq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int SUM_W    = CNT_W + 1;

    localparam int OP_W     = 3;
    localparam int VAL_W    = 32;
    localparam int STAT_W   = 2;
    localparam int TOTAL_W  = 5;

    localparam int IN_BITS  = OP_W + VAL_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = VAL_W + STAT_W + TOTAL_W + VAL_W + VAL_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic signed [VAL_W-1:0] NONE_VALUE = -32'sd1;

endpackage

>>> rtl/bdq_ring_ram.sv
module bdq_ring_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output logic [WIDTH-1:0]  o_rdata_a,
    output logic [WIDTH-1:0]  o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read before write: a same-cycle write is forwarded by the user
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> rtl/bounded_deque.sv
// Double-ended queue on a ring memory with one write and two read ports.
// Result: the request and the ring read are registered on accept, and the result word
// in S_READ once the output slot is free. A new request is taken only in S_IDLE, so the
// ring read of the new front and back entries ends before another request is accepted.
// Reset (i_rst_n low, synchronous): queue empty, front index zero, no result pending.
// The ring contents are not cleared; entries are read only after being written.
module bounded_deque (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // op [2:0], push_value [34:3], zero fill above
    input  logic [bdq_pkg::IN_W-1:0]   i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // popped_value [31:0], status [33:32], entry_total [38:34],
    // front_value [70:39], back_value [102:71], zero fill above
    output logic [bdq_pkg::OUT_W-1:0]  o_m_axis_tdata
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state r_state;

    logic [bdq_pkg::IDX_W-1:0]        r_front;
    logic [bdq_pkg::CNT_W-1:0]        r_count;
    logic signed [bdq_pkg::VAL_W-1:0] r_front_val;
    logic signed [bdq_pkg::VAL_W-1:0] r_back_val;

    logic signed [bdq_pkg::VAL_W-1:0]  r_push_val;
    logic signed [bdq_pkg::VAL_W-1:0]  r_popped;
    logic [bdq_pkg::STAT_W-1:0]        r_status;
    logic                              r_fwd_a;
    logic                              r_fwd_b;

    logic                              r_out_valid;
    logic [bdq_pkg::OUT_W-1:0]         r_out_data;

    logic [bdq_pkg::OP_W-1:0]          req_op;
    logic signed [bdq_pkg::VAL_W-1:0]  req_val;
    logic                              accept;
    logic                              is_full;
    logic                              is_empty;
    logic [bdq_pkg::IDX_W-1:0]         front_prev;
    logic [bdq_pkg::IDX_W-1:0]         front_next;
    logic [bdq_pkg::IDX_W-1:0]         n_front;
    logic [bdq_pkg::CNT_W-1:0]         n_count;
    logic [bdq_pkg::SUM_W-1:0]         back_sum;
    logic [bdq_pkg::IDX_W-1:0]         n_back;
    logic                              wr_en;
    logic [bdq_pkg::IDX_W-1:0]         wr_addr;
    logic [bdq_pkg::STAT_W-1:0]        n_status;
    logic signed [bdq_pkg::VAL_W-1:0]  n_popped;

    logic [bdq_pkg::VAL_W-1:0]         rd_a;
    logic [bdq_pkg::VAL_W-1:0]         rd_b;
    logic signed [bdq_pkg::VAL_W-1:0]  res_front;
    logic signed [bdq_pkg::VAL_W-1:0]  res_back;
    logic                              out_free;

    assign req_op  = i_s_axis_tdata[bdq_pkg::OP_W-1:0];
    assign req_val = i_s_axis_tdata[bdq_pkg::OP_W +: bdq_pkg::VAL_W];

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    assign is_full  = (r_count == bdq_pkg::CNT_W'(bdq_pkg::CAPACITY));
    assign is_empty = (r_count == '0);

    assign front_prev = (r_front == '0) ? bdq_pkg::IDX_W'(bdq_pkg::CAPACITY - 1)
                                        : r_front - bdq_pkg::IDX_W'(1);
    assign front_next = (r_front == bdq_pkg::IDX_W'(bdq_pkg::CAPACITY - 1)) ? '0
                                        : r_front + bdq_pkg::IDX_W'(1);

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        wr_en    = 1'b0;
        n_status = bdq_pkg::ST_OK;
        n_popped = bdq_pkg::NONE_VALUE;
        case (req_op)
            bdq_pkg::OP_PUSH_FRONT: begin
                if (is_full) begin
                    n_status = bdq_pkg::ST_FULL;
                end else begin
                    n_front = front_prev;
                    n_count = r_count + bdq_pkg::CNT_W'(1);
                    wr_en   = 1'b1;
                end
            end
            bdq_pkg::OP_PUSH_BACK: begin
                if (is_full) begin
                    n_status = bdq_pkg::ST_FULL;
                end else begin
                    n_count = r_count + bdq_pkg::CNT_W'(1);
                    wr_en   = 1'b1;
                end
            end
            bdq_pkg::OP_POP_FRONT: begin
                if (is_empty) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    n_popped = r_front_val;
                    n_front  = front_next;
                    n_count  = r_count - bdq_pkg::CNT_W'(1);
                end
            end
            bdq_pkg::OP_POP_BACK: begin
                if (is_empty) begin
                    n_status = bdq_pkg::ST_EMPTY;
                end else begin
                    n_popped = r_back_val;
                    n_count  = r_count - bdq_pkg::CNT_W'(1);
                end
            end
            bdq_pkg::OP_CLEAR: begin
                n_front = '0;
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    // back index after the step; meaningless when the queue ends up empty
    always_comb begin
        back_sum = bdq_pkg::SUM_W'(n_front) + bdq_pkg::SUM_W'(n_count)
                   - bdq_pkg::SUM_W'(1);
        if (back_sum >= bdq_pkg::SUM_W'(bdq_pkg::CAPACITY)) begin
            back_sum = back_sum - bdq_pkg::SUM_W'(bdq_pkg::CAPACITY);
        end
        n_back = back_sum[bdq_pkg::IDX_W-1:0];
    end

    assign wr_addr = (req_op == bdq_pkg::OP_PUSH_FRONT) ? n_front : n_back;

    bdq_ring_ram #(
        .DEPTH (bdq_pkg::CAPACITY),
        .WIDTH (bdq_pkg::VAL_W)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (accept && wr_en),
        .i_waddr   (wr_addr),
        .i_wdata   (req_val),
        .i_re      (accept),
        .i_raddr_a (n_front),
        .i_raddr_b (n_back),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (accept) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // capture the request; flag reads that hit the entry written this cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_push_val <= req_val;
            r_popped   <= n_popped;
            r_status   <= n_status;
            r_fwd_a    <= wr_en && (wr_addr == n_front);
            r_fwd_b    <= wr_en && (wr_addr == n_back);
        end
    end

    assign res_front = (r_count == '0) ? bdq_pkg::NONE_VALUE
                     : (r_fwd_a ? r_push_val : $signed(rd_a));
    assign res_back  = (r_count == '0) ? bdq_pkg::NONE_VALUE
                     : (r_fwd_b ? r_push_val : $signed(rd_b));

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (r_out_valid && i_m_axis_tready) begin
                        r_out_valid <= 1'b0;
                    end
                    if (accept) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // hold the read data until the output slot frees up
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ && out_free) begin
            r_front_val <= res_front;
            r_back_val  <= res_back;
            r_out_data  <= bdq_pkg::OUT_W'({res_back, res_front,
                                            bdq_pkg::TOTAL_W'(r_count),
                                            r_status, r_popped});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

>>> rtl/bdq_checker.sv
module bdq_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    input  logic                       o_s_axis_tready,
    input  logic [bdq_pkg::IN_W-1:0]   i_s_axis_tdata,
    input  logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    input  logic [bdq_pkg::OUT_W-1:0]  o_m_axis_tdata
);

    logic [bdq_pkg::VAL_W-1:0]   chk_popped;
    logic [bdq_pkg::STAT_W-1:0]  chk_status;
    logic [bdq_pkg::TOTAL_W-1:0] chk_total;
    logic [bdq_pkg::VAL_W-1:0]   chk_front;
    logic [bdq_pkg::VAL_W-1:0]   chk_back;

    assign chk_popped = o_m_axis_tdata[31:0];
    assign chk_status = o_m_axis_tdata[33:32];
    assign chk_total  = o_m_axis_tdata[38:34];
    assign chk_front  = o_m_axis_tdata[70:39];
    assign chk_back   = o_m_axis_tdata[102:71];

    // one request in flight: no second accept right after the first
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("request accepted while previous one still in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result dropped or changed");

    a_empty_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && chk_total == '0) |->
        (chk_front == bdq_pkg::NONE_VALUE && chk_back == bdq_pkg::NONE_VALUE))
        else $error("empty queue reports front or back value");

    a_fail_no_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && chk_status != bdq_pkg::ST_OK) |->
        (chk_popped == bdq_pkg::NONE_VALUE))
        else $error("failed request reports a popped value");

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (chk_total <= bdq_pkg::TOTAL_W'(bdq_pkg::CAPACITY)))
        else $error("entry total exceeds capacity");

endmodule

bind bounded_deque bdq_checker u_bdq_checker (.*);
